### src/rpdr_pkg.sv
package rpdr_pkg;

  localparam int CordicSteps = 20;
  localparam logic [31:0] CordicGain = 32'd652032874;
  localparam logic [31:0] QuarterTurn = 32'h4000_0000;
  localparam logic [31:0] HalfTurn = 32'h8000_0000;
  localparam logic [31:0] FifteenDeg = 32'd178956971;
  localparam logic [31:0] TimeMax = 32'hFFFF_FFFF;
  // floor(echo * 65536 / 58) equals ((echo << 15) * EchoRecip) >> 36 over the echo range
  localparam logic [31:0] EchoRecip = 32'd2369637129;

  typedef enum logic [2:0] {
    ACT_NONE = 3'd0,
    ACT_FWD  = 3'd1,
    ACT_BWD  = 3'd2,
    ACT_LEFT = 3'd3,
    ACT_RIGHT = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    CFG_START = 3'd0,
    CFG_STOP  = 3'd1,
    CFG_SPEED = 3'd2,
    CFG_LRATE = 3'd3,
    CFG_RRATE = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TIMER,
    ST_DIST,
    ST_CORDIC,
    ST_MUL_S,
    ST_MUL_C,
    ST_APPLY,
    ST_ACTION,
    ST_HIT_SETUP,
    ST_HIT_CORDIC,
    ST_HIT_MUL_S,
    ST_HIT_MUL_C,
    ST_HIT_STORE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [31:0] current_time;
    logic [2:0]  commanded_action;
    logic [15:0] echo_left;
    logic [15:0] echo_right;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        heading;
    logic signed [31:0] hit_left_x;
    logic signed [31:0] hit_left_y;
    logic signed [31:0] hit_right_x;
    logic signed [31:0] hit_right_y;
    logic               dir_left;
    logic               dir_right;
    logic [2:0]         power_left;
    logic [2:0]         power_right;
  } out_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'd536870912;
      5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;
      5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667338;
      5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679839;
      5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;
      5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41721;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] r;
    r = {1'b0, a} + {17'd0, b};
    return r[32] ? TimeMax : r[31:0];
  endfunction

endpackage

### src/robot_pose_dead_reckoning_core.sv
// per input beat, on the shared cordic and multiplier: a check of each of the four timers,
// for an active linear timer a distance product, 20 cordic steps and two products, then the update;
// for an active turn timer the heading update; then the action update and per obstacle point
// setup, 20 cordic steps, two products and store, and the output; one beat at a time,
// ready only while idle with no result waiting
// reset: asynchronous active low, pose, timers, action and config registers cleared to zero
module robot_pose_dead_reckoning_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rpdr_pkg::in_t      in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rpdr_pkg::out_t     out_data_o
);

  logic [63:0] start_q, stop_q;
  logic [31:0] speed_q, lrate_q, rrate_q;
  logic [31:0] px_q, py_q, hd_q, last_q;
  logic [2:0]  act_q;
  logic [31:0] tstart_q [1:4];
  logic [31:0] tend_q [1:4];

  rpdr_pkg::state_e st_q, st_d;
  rpdr_pkg::in_t in_q;
  logic [2:0]  ti_q;
  logic [31:0] dur_q;
  logic [31:0] dist_q;
  logic signed [35:0] cx_q, cy_q, cz_q;
  logic [4:0]  it_q;
  logic        flip_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] p_q;
  logic        hit_q;
  logic        ovalid_q;
  rpdr_pkg::out_t out_q;

  logic [31:0] lo, hi, tst, ten;
  logic [63:0] mul_u;
  logic [31:0] ang;
  logic signed [31:0] sprod;
  logic [2:0]  cmd;
  logic [31:0] turn_rate;
  logic [15:0] echo_sel;

  // last cordic step also applies the half-turn sign fold
  function automatic logic signed [35:0] sres_fix(input logic neg);
    logic signed [35:0] y;
    y = neg ? cy_q - (cx_q >>> it_q) : cy_q + (cx_q >>> it_q);
    return flip_q ? -y : y;
  endfunction

  function automatic logic signed [35:0] cres_fix(input logic neg);
    logic signed [35:0] x;
    x = neg ? cx_q + (cy_q >>> it_q) : cx_q - (cy_q >>> it_q);
    return flip_q ? -x : x;
  endfunction

  assign in_ready_o = (st_q == rpdr_pkg::ST_IDLE) && !ovalid_q;
  assign out_valid_o = ovalid_q;
  assign out_data_o = out_q;
  assign cmd = (in_q.commanded_action > rpdr_pkg::ACT_RIGHT) ? rpdr_pkg::ACT_NONE
                                                             : in_q.commanded_action;
  assign turn_rate = (ti_q == rpdr_pkg::ACT_LEFT) ? lrate_q : rrate_q;
  assign echo_sel = hit_q ? in_q.echo_right : in_q.echo_left;

  always_comb begin
    tst = tstart_q[1];
    ten = tend_q[1];
    case (ti_q)
      rpdr_pkg::ACT_BWD: begin tst = tstart_q[2]; ten = tend_q[2]; end
      rpdr_pkg::ACT_LEFT: begin tst = tstart_q[3]; ten = tend_q[3]; end
      rpdr_pkg::ACT_RIGHT: begin tst = tstart_q[4]; ten = tend_q[4]; end
      default: ;
    endcase
    lo = (tst > last_q) ? tst : last_q;
    hi = (ten < in_q.current_time) ? ten : in_q.current_time;
  end

  // shared multiplier
  always_comb begin
    mul_u = 64'd0;
    case (st_q)
      rpdr_pkg::ST_DIST: mul_u = 64'(speed_q) * 64'(dur_q);
      rpdr_pkg::ST_MUL_S, rpdr_pkg::ST_HIT_MUL_S: mul_u = 64'(cy_q) * 64'(dist_q);
      rpdr_pkg::ST_MUL_C, rpdr_pkg::ST_HIT_MUL_C: mul_u = 64'(cx_q) * 64'(dist_q);
      rpdr_pkg::ST_APPLY: mul_u = 64'(turn_rate) * 64'(dur_q);
      rpdr_pkg::ST_HIT_SETUP: mul_u = 64'({echo_sel, 15'd0}) * 64'(rpdr_pkg::EchoRecip);
      default: mul_u = 64'd0;
    endcase
  end

  assign sprod = 32'(prod_q >>> 30);

  always_comb begin
    ang = hd_q;
    if (st_q == rpdr_pkg::ST_HIT_SETUP) begin
      ang = hit_q ? hd_q - rpdr_pkg::FifteenDeg : hd_q + rpdr_pkg::FifteenDeg;
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      rpdr_pkg::ST_IDLE: if (in_valid_i && in_ready_o) st_d = rpdr_pkg::ST_TIMER;
      rpdr_pkg::ST_TIMER: begin
        if (lo < hi) begin
          if (ti_q == rpdr_pkg::ACT_FWD || ti_q == rpdr_pkg::ACT_BWD) st_d = rpdr_pkg::ST_DIST;
          else st_d = rpdr_pkg::ST_APPLY;
        end else if (ti_q == rpdr_pkg::ACT_RIGHT) begin
          st_d = rpdr_pkg::ST_ACTION;
        end
      end
      rpdr_pkg::ST_DIST: st_d = rpdr_pkg::ST_CORDIC;
      rpdr_pkg::ST_CORDIC: if (it_q == 5'(rpdr_pkg::CordicSteps - 1)) st_d = rpdr_pkg::ST_MUL_S;
      rpdr_pkg::ST_MUL_S: st_d = rpdr_pkg::ST_MUL_C;
      rpdr_pkg::ST_MUL_C: st_d = rpdr_pkg::ST_APPLY;
      rpdr_pkg::ST_APPLY:
        st_d = (ti_q == rpdr_pkg::ACT_RIGHT) ? rpdr_pkg::ST_ACTION : rpdr_pkg::ST_TIMER;
      rpdr_pkg::ST_ACTION: st_d = rpdr_pkg::ST_HIT_SETUP;
      rpdr_pkg::ST_HIT_SETUP: st_d = rpdr_pkg::ST_HIT_CORDIC;
      rpdr_pkg::ST_HIT_CORDIC:
        if (it_q == 5'(rpdr_pkg::CordicSteps - 1)) st_d = rpdr_pkg::ST_HIT_MUL_S;
      rpdr_pkg::ST_HIT_MUL_S: st_d = rpdr_pkg::ST_HIT_MUL_C;
      rpdr_pkg::ST_HIT_MUL_C: st_d = rpdr_pkg::ST_HIT_STORE;
      rpdr_pkg::ST_HIT_STORE: st_d = hit_q ? rpdr_pkg::ST_OUT : rpdr_pkg::ST_HIT_SETUP;
      rpdr_pkg::ST_OUT: st_d = rpdr_pkg::ST_IDLE;
      default: st_d = rpdr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= rpdr_pkg::ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0; stop_q <= '0; speed_q <= '0; lrate_q <= '0; rrate_q <= '0;
      px_q <= '0; py_q <= '0; hd_q <= '0; last_q <= '0; act_q <= rpdr_pkg::ACT_NONE;
      for (int k = 1; k <= 4; k++) begin
        tstart_q[k] <= '0;
        tend_q[k] <= '0;
      end
      ovalid_q <= 1'b0;
      ti_q <= rpdr_pkg::ACT_FWD; it_q <= '0; hit_q <= 1'b0;
      dur_q <= '0; dist_q <= '0; cx_q <= '0; cy_q <= '0; cz_q <= '0;
      flip_q <= 1'b0; prod_q <= '0; p_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rpdr_pkg::CFG_START: start_q <= cfg_data_i;
          rpdr_pkg::CFG_STOP:  stop_q <= cfg_data_i;
          rpdr_pkg::CFG_SPEED: speed_q <= cfg_data_i[31:0];
          rpdr_pkg::CFG_LRATE: lrate_q <= cfg_data_i[31:0];
          rpdr_pkg::CFG_RRATE: rrate_q <= cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      case (st_q)
        rpdr_pkg::ST_IDLE: begin
          ti_q <= rpdr_pkg::ACT_FWD;
          hit_q <= 1'b0;
        end
        rpdr_pkg::ST_TIMER: begin
          dur_q <= hi - lo;
          if (!(lo < hi) && ti_q != rpdr_pkg::ACT_RIGHT) ti_q <= ti_q + 3'd1;
        end
        rpdr_pkg::ST_DIST: begin
          dist_q <= (mul_u[63:32] != 32'd0) ? rpdr_pkg::TimeMax : mul_u[31:0];
        end
        rpdr_pkg::ST_CORDIC, rpdr_pkg::ST_HIT_CORDIC: begin
          if (it_q == 5'(rpdr_pkg::CordicSteps - 1)) begin
            cy_q <= sres_fix(cz_q < 0);
            cx_q <= cres_fix(cz_q < 0);
          end else if (cz_q >= 0) begin
            cx_q <= cx_q - (cy_q >>> it_q);
            cy_q <= cy_q + (cx_q >>> it_q);
          end else begin
            cx_q <= cx_q + (cy_q >>> it_q);
            cy_q <= cy_q - (cx_q >>> it_q);
          end
          if (cz_q >= 0) cz_q <= cz_q - 36'(rpdr_pkg::atan_lut(it_q));
          else cz_q <= cz_q + 36'(rpdr_pkg::atan_lut(it_q));
          it_q <= it_q + 5'd1;
        end
        rpdr_pkg::ST_MUL_S, rpdr_pkg::ST_HIT_MUL_S: begin
          prod_q <= $signed(mul_u);
        end
        rpdr_pkg::ST_MUL_C, rpdr_pkg::ST_HIT_MUL_C: begin
          p_q <= sprod;
          prod_q <= $signed(mul_u);
        end
        rpdr_pkg::ST_APPLY: begin
          case (ti_q)
            rpdr_pkg::ACT_FWD: begin
              px_q <= px_q - p_q;
              py_q <= py_q + sprod;
            end
            rpdr_pkg::ACT_BWD: begin
              px_q <= px_q + p_q;
              py_q <= py_q - sprod;
            end
            rpdr_pkg::ACT_LEFT: hd_q <= hd_q + mul_u[31:0];
            rpdr_pkg::ACT_RIGHT: hd_q <= hd_q - mul_u[31:0];
            default: ;
          endcase
          if (ti_q != rpdr_pkg::ACT_RIGHT) ti_q <= ti_q + 3'd1;
        end
        rpdr_pkg::ST_ACTION: begin
          last_q <= in_q.current_time;
          if (cmd != act_q) begin
            case (cmd)
              rpdr_pkg::ACT_FWD: begin
                tstart_q[1] <= rpdr_pkg::sat_add(in_q.current_time, start_q[15:0]);
                tend_q[1] <= rpdr_pkg::TimeMax;
              end
              rpdr_pkg::ACT_BWD: begin
                tstart_q[2] <= rpdr_pkg::sat_add(in_q.current_time, start_q[31:16]);
                tend_q[2] <= rpdr_pkg::TimeMax;
              end
              rpdr_pkg::ACT_LEFT: begin
                tstart_q[3] <= rpdr_pkg::sat_add(in_q.current_time, start_q[47:32]);
                tend_q[3] <= rpdr_pkg::TimeMax;
              end
              rpdr_pkg::ACT_RIGHT: begin
                tstart_q[4] <= rpdr_pkg::sat_add(in_q.current_time, start_q[63:48]);
                tend_q[4] <= rpdr_pkg::TimeMax;
              end
              default: ;
            endcase
            case (act_q)
              rpdr_pkg::ACT_FWD:
                tend_q[1] <= rpdr_pkg::sat_add(in_q.current_time, stop_q[15:0]);
              rpdr_pkg::ACT_BWD:
                tend_q[2] <= rpdr_pkg::sat_add(in_q.current_time, stop_q[31:16]);
              rpdr_pkg::ACT_LEFT:
                tend_q[3] <= rpdr_pkg::sat_add(in_q.current_time, stop_q[47:32]);
              rpdr_pkg::ACT_RIGHT:
                tend_q[4] <= rpdr_pkg::sat_add(in_q.current_time, stop_q[63:48]);
              default: ;
            endcase
            act_q <= cmd;
          end
        end
        rpdr_pkg::ST_HIT_SETUP: begin
          dist_q <= {4'd0, mul_u[63:36]};
        end
        rpdr_pkg::ST_HIT_STORE: begin
          hit_q <= 1'b1;
        end
        rpdr_pkg::ST_OUT: begin
          ovalid_q <= 1'b1;
        end
        default: ;
      endcase
      if (st_q == rpdr_pkg::ST_DIST || st_q == rpdr_pkg::ST_HIT_SETUP) begin
        it_q <= '0;
        cx_q <= 36'(rpdr_pkg::CordicGain);
        cy_q <= '0;
        if (ang > rpdr_pkg::QuarterTurn && ang < rpdr_pkg::QuarterTurn * 3) begin
          flip_q <= 1'b1;
          cz_q <= 36'(signed'(ang - rpdr_pkg::HalfTurn));
        end else begin
          flip_q <= 1'b0;
          cz_q <= 36'(signed'(ang));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    if (st_q == rpdr_pkg::ST_HIT_STORE) begin
      if (!hit_q) begin
        out_q.hit_left_x <= px_q - p_q;
        out_q.hit_left_y <= py_q + sprod;
      end else begin
        out_q.hit_right_x <= px_q - p_q;
        out_q.hit_right_y <= py_q + sprod;
      end
    end
    if (st_q == rpdr_pkg::ST_OUT) begin
      out_q.pos_x <= px_q;
      out_q.pos_y <= py_q;
      out_q.heading <= hd_q;
      out_q.dir_left <= (act_q == rpdr_pkg::ACT_BWD) || (act_q == rpdr_pkg::ACT_LEFT);
      out_q.dir_right <= (act_q == rpdr_pkg::ACT_BWD) || (act_q == rpdr_pkg::ACT_RIGHT);
      out_q.power_left <= (act_q == rpdr_pkg::ACT_NONE) ? 3'd0 : 3'd7;
      out_q.power_right <= (act_q == rpdr_pkg::ACT_NONE) ? 3'd0 : 3'd7;
    end
  end

endmodule

### src/rpdr_checker.sv
module rpdr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready while busy");

  a_no_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready with pending result");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o) else $error("result too early");

endmodule

bind robot_pose_dead_reckoning_core rpdr_checker u_rpdr_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i)
);

### tb/tb_robot_pose_dead_reckoning_core.sv
module tb_robot_pose_dead_reckoning_core;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           cfg_we_i = 1'b0;
  logic [2:0]     cfg_idx_i = '0;
  logic [63:0]    cfg_data_i = '0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  rpdr_pkg::in_t  in_data_i = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  rpdr_pkg::out_t out_data_o;

  robot_pose_dead_reckoning_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor copy of the block
  logic [63:0] m_start_dly, m_stop_dly;
  logic [31:0] m_speed, m_lrate, m_rrate;
  logic [31:0] m_x, m_y, m_hdg, m_last;
  logic [2:0]  m_act;
  logic [31:0] m_tstart [5];
  logic [31:0] m_tend [5];

  rpdr_pkg::out_t pose_q [$];
  int   n_bad = 0;
  int   n_out = 0;
  int   n_in = 0;
  bit   hold_off = 1'b0;
  bit   timed_out = 1'b0;

  localparam longint AtanTab [20] = '{
    536870912, 316933406, 167458907, 85004756, 42667338,
    21354465, 10679839, 5340245, 2670163, 1335087,
    667544, 333772, 166886, 83443, 41721,
    20861, 10430, 5215, 2608, 1304};

  function automatic longint fl_shr(longint v, int n);
    return v >>> n;
  endfunction

  task automatic rot_sincos(input logic [31:0] ang, output longint s, output longint c);
    bit     flip;
    longint x, y, z, dx, dy;
    flip = 1'b0;
    x = 652032874;
    y = 0;
    if (ang > rpdr_pkg::QuarterTurn && ang < 32'hC000_0000) begin
      ang = ang - rpdr_pkg::HalfTurn;
      flip = 1'b1;
    end
    z = longint'($signed(ang));
    for (int i = 0; i < 20; i++) begin
      dx = fl_shr(y, i);
      dy = fl_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTab[i];
      end else begin
        x += dx; y -= dy; z += AtanTab[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] r;
    r = {1'b0, a} + {1'b0, b};
    return r[32] ? rpdr_pkg::TimeMax : r[31:0];
  endfunction

  function automatic logic [31:0] dly_of(logic [63:0] r, logic [2:0] a);
    if (a < rpdr_pkg::ACT_FWD || a > rpdr_pkg::ACT_RIGHT) return 0;
    return 32'(r[(a - 1) * 16 +: 16]);
  endfunction

  task automatic move_for(input logic [2:0] a, input logic [31:0] dur);
    longint s, c, p, q;
    logic [63:0] span;
    if (a == rpdr_pkg::ACT_FWD || a == rpdr_pkg::ACT_BWD) begin
      span = 64'(m_speed) * 64'(dur);
      if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
      rot_sincos(m_hdg, s, c);
      p = fl_shr(s * longint'(span), 30);
      q = fl_shr(c * longint'(span), 30);
      if (a == rpdr_pkg::ACT_FWD) begin
        m_x = m_x - 32'(p); m_y = m_y + 32'(q);
      end else begin
        m_x = m_x + 32'(p); m_y = m_y - 32'(q);
      end
    end else if (a == rpdr_pkg::ACT_LEFT) begin
      m_hdg = m_hdg + m_lrate * dur;
    end else if (a == rpdr_pkg::ACT_RIGHT) begin
      m_hdg = m_hdg - m_rrate * dur;
    end
  endtask

  task automatic obstacle_at(input logic [31:0] ang, input logic [15:0] echo,
                             output logic [31:0] hx, output logic [31:0] hy);
    longint s, c, d;
    d = longint'({echo, 16'd0}) / 58;
    rot_sincos(ang, s, c);
    hx = m_x - 32'(fl_shr(s * d, 30));
    hy = m_y + 32'(fl_shr(c * d, 30));
  endtask

  task automatic pose_step(input rpdr_pkg::in_t b, output rpdr_pkg::out_t r);
    logic [2:0]  cmd;
    logic [31:0] lo, hi, hx, hy;
    cmd = (b.commanded_action > rpdr_pkg::ACT_RIGHT) ? rpdr_pkg::ACT_NONE : b.commanded_action;
    for (int i = 1; i <= 4; i++) begin
      lo = m_tstart[i] > m_last ? m_tstart[i] : m_last;
      hi = m_tend[i] < b.current_time ? m_tend[i] : b.current_time;
      if (lo < hi) move_for(3'(i), hi - lo);
    end
    m_last = b.current_time;
    if (cmd != m_act) begin
      m_tstart[cmd] = add_sat(b.current_time, dly_of(m_start_dly, cmd));
      m_tend[cmd] = rpdr_pkg::TimeMax;
      m_tend[m_act] = add_sat(b.current_time, dly_of(m_stop_dly, m_act));
      m_act = cmd;
    end
    r = '0;
    case (m_act)
      rpdr_pkg::ACT_FWD: begin r.power_left = 7; r.power_right = 7; end
      rpdr_pkg::ACT_BWD: begin
        r.dir_left = 1; r.dir_right = 1; r.power_left = 7; r.power_right = 7;
      end
      rpdr_pkg::ACT_LEFT: begin r.dir_left = 1; r.power_left = 7; r.power_right = 7; end
      rpdr_pkg::ACT_RIGHT: begin r.dir_right = 1; r.power_left = 7; r.power_right = 7; end
      default: ;
    endcase
    r.pos_x = m_x;
    r.pos_y = m_y;
    r.heading = m_hdg;
    obstacle_at(m_hdg + rpdr_pkg::FifteenDeg, b.echo_left, hx, hy);
    r.hit_left_x = hx; r.hit_left_y = hy;
    obstacle_at(m_hdg - rpdr_pkg::FifteenDeg, b.echo_right, hx, hy);
    r.hit_right_x = hx; r.hit_right_y = hy;
  endtask

  task automatic note_bad(input string what, input logic [31:0] e, input logic [31:0] a);
    n_bad++;
    if (n_bad <= 10)
      $display("mismatch beat %0d %s: expected %h got %h", n_out, what, e, a);
  endtask

  // result checker
  always @(posedge clk_i) begin
    rpdr_pkg::out_t e, a;
    if (rst_ni && out_valid_o && out_ready_i) begin
      a = out_data_o;
      if (pose_q.size() == 0) begin
        note_bad("unexpected beat", 0, 0);
      end else begin
        e = pose_q.pop_front();
        if (e.pos_x !== a.pos_x) note_bad("pos_x", e.pos_x, a.pos_x);
        if (e.pos_y !== a.pos_y) note_bad("pos_y", e.pos_y, a.pos_y);
        if (e.heading !== a.heading) note_bad("heading", e.heading, a.heading);
        if (e.hit_left_x !== a.hit_left_x) note_bad("hit_left_x", e.hit_left_x, a.hit_left_x);
        if (e.hit_left_y !== a.hit_left_y) note_bad("hit_left_y", e.hit_left_y, a.hit_left_y);
        if (e.hit_right_x !== a.hit_right_x)
          note_bad("hit_right_x", e.hit_right_x, a.hit_right_x);
        if (e.hit_right_y !== a.hit_right_y)
          note_bad("hit_right_y", e.hit_right_y, a.hit_right_y);
        if (e.dir_left !== a.dir_left) note_bad("dir_left", e.dir_left, a.dir_left);
        if (e.dir_right !== a.dir_right) note_bad("dir_right", e.dir_right, a.dir_right);
        if (e.power_left !== a.power_left) note_bad("power_left", e.power_left, a.power_left);
        if (e.power_right !== a.power_right)
          note_bad("power_right", e.power_right, a.power_right);
      end
      n_out++;
    end
  end

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk_i) begin
    int ph;
    ph = $urandom_range(0, 15);
    if (hold_off) out_ready_i <= 1'b0;
    else if (n_in % 200 < 60) out_ready_i <= 1'b1;
    else out_ready_i <= (ph > 4);
  end

  task automatic cfg_write(input rpdr_pkg::cfg_idx_e idx, input logic [63:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    case (idx)
      rpdr_pkg::CFG_START: m_start_dly = v;
      rpdr_pkg::CFG_STOP:  m_stop_dly = v;
      rpdr_pkg::CFG_SPEED: m_speed = v[31:0];
      rpdr_pkg::CFG_LRATE: m_lrate = v[31:0];
      rpdr_pkg::CFG_RRATE: m_rrate = v[31:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain;
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // one beat; expectation pushed when accepted
  task automatic send_beat(input rpdr_pkg::in_t b);
    rpdr_pkg::out_t r;
    in_valid_i <= 1'b1;
    in_data_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pose_step(b, r);
    pose_q.push_back(r);
    n_in++;
  endtask

  task automatic idle_gap;
    int g;
    g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 30) : 0;
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  function automatic logic [63:0] rand_dly4(int mx);
    return {16'($urandom_range(0, mx)), 16'($urandom_range(0, mx)),
            16'($urandom_range(0, mx)), 16'($urandom_range(0, mx))};
  endfunction

  typedef struct {
    rpdr_pkg::in_t b;
    bit            fixed;
    logic [31:0]   hdg;
    logic [2:0]    pw;
  } row_t;

  row_t rows [$];
  logic [31:0] now_ms;

  initial begin
    rpdr_pkg::in_t b;
    m_start_dly = 0; m_stop_dly = 0; m_speed = 0; m_lrate = 0; m_rrate = 0;
    m_x = 0; m_y = 0; m_hdg = 0; m_last = 0; m_act = rpdr_pkg::ACT_NONE;
    for (int i = 0; i < 5; i++) begin
      m_tstart[i] = 0; m_tend[i] = 0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows: zero registers mean nothing moves, heading stays zero
    rows.push_back('{'{32'd0, rpdr_pkg::ACT_NONE, 16'd0, 16'd0}, 1, 32'd0, 3'd0});
    rows.push_back('{'{32'd10, rpdr_pkg::ACT_FWD, 16'hFFFF, 16'hFFFF}, 1, 32'd0, 3'd7});
    rows.push_back('{'{32'd20, rpdr_pkg::ACT_BWD, 16'd0, 16'hFFFF}, 1, 32'd0, 3'd7});
    rows.push_back('{'{32'd30, rpdr_pkg::ACT_LEFT, 16'hFFFF, 16'd0}, 1, 32'd0, 3'd7});
    rows.push_back('{'{32'd40, rpdr_pkg::ACT_RIGHT, 16'd58, 16'd1}, 1, 32'd0, 3'd7});
    rows.push_back('{'{32'd50, 3'd7, 16'd1, 16'd58}, 1, 32'd0, 3'd0});
    foreach (rows[k]) begin
      send_beat(rows[k].b);
      if (pose_q[$].heading !== rows[k].hdg || pose_q[$].power_left !== rows[k].pw)
        note_bad("directed row", rows[k].hdg, pose_q[$].heading);
    end
    in_valid_i <= 1'b0;
    drain();

    cfg_write(rpdr_pkg::CFG_START, 64'h0003_0002_0001_0000);
    cfg_write(rpdr_pkg::CFG_STOP, 64'h0000_0001_0002_0003);
    cfg_write(rpdr_pkg::CFG_SPEED, 64'h0001_8000);
    cfg_write(rpdr_pkg::CFG_LRATE, 64'd11930465);
    cfg_write(rpdr_pkg::CFG_RRATE, 64'd7000000);
    rows.delete();
    rows.push_back('{'{32'd100, rpdr_pkg::ACT_FWD, 16'd1000, 16'd2000}, 0, 0, 0});
    rows.push_back('{'{32'd150, rpdr_pkg::ACT_LEFT, 16'd300, 16'd400}, 0, 0, 0});
    rows.push_back('{'{32'd151, rpdr_pkg::ACT_BWD, 16'd5, 16'd6}, 0, 0, 0});
    rows.push_back('{'{32'd120, rpdr_pkg::ACT_RIGHT, 16'd7, 16'd8}, 0, 0, 0});
    rows.push_back('{'{32'd400, 3'd5, 16'd9, 16'd10}, 0, 0, 0});
    rows.push_back('{'{32'd401, rpdr_pkg::ACT_FWD, 16'd11, 16'd12}, 0, 0, 0});
    rows.push_back('{'{32'hFFFF_FFF0, rpdr_pkg::ACT_LEFT, 16'hFFFF, 16'hFFFF}, 0, 0, 0});
    rows.push_back('{'{32'hFFFF_FFFF, 3'd6, 16'd0, 16'd0}, 0, 0, 0});
    foreach (rows[k]) send_beat(rows[k].b);
    in_valid_i <= 1'b0;
    drain();

    // random phases over several settings, extremes included
    now_ms = 0;
    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(rpdr_pkg::CFG_START,
                ph == 1 ? 64'hFFFF_FFFF_FFFF_FFFF : rand_dly4(ph == 0 ? 0 : 50));
      cfg_write(rpdr_pkg::CFG_STOP,
                ph == 1 ? 64'hFFFF_FFFF_FFFF_FFFF : rand_dly4(ph == 0 ? 0 : 50));
      cfg_write(rpdr_pkg::CFG_SPEED,
                ph == 2 ? 64'hFFFF_FFFF : 64'($urandom_range(0, 32'h0004_0000)));
      cfg_write(rpdr_pkg::CFG_LRATE, ph == 2 ? 64'hFFFF_FFFF : 64'($urandom()));
      cfg_write(rpdr_pkg::CFG_RRATE, ph == 2 ? 64'hFFFF_FFFF : 64'($urandom()));
      now_ms = ph == 3 ? 32'hFFFF_0000 : 0;
      for (int k = 0; k < 200; k++) begin
        if (ph == 4 && k == 20) begin
          fork
            begin
              hold_off = 1'b1;
              repeat (1500) @(posedge clk_i);
              hold_off = 1'b0;
            end
          join_none
        end
        if (ph == 5 && k == 100) begin
          in_valid_i <= 1'b0;
          while (pose_q.size() != 0) @(posedge clk_i);
        end
        if ($urandom_range(0, 19) == 0) now_ms = now_ms - $urandom_range(0, 100);
        else now_ms = now_ms + $urandom_range(0, ph == 6 ? 70000 : 200);
        b.current_time = $urandom_range(0, 49) == 0 ? $urandom() : now_ms;
        b.commanded_action = $urandom_range(0, 9) == 0 ? 3'($urandom_range(5, 7))
                                                       : 3'($urandom_range(0, 4));
        b.echo_left = 16'($urandom());
        b.echo_right = 16'($urandom());
        send_beat(b);
        idle_gap();
      end
      in_valid_i <= 1'b0;
      drain();
    end

    $display("covered %0d beats over eight register settings, including saturated delays,",
             n_in);
    $display("full-scale speed and rates, backwards time and a long receiver hold-off");
    if (n_bad == 0 && !timed_out) begin
      $display("tb_robot_pose_dead_reckoning_core OK");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("tb_robot_pose_dead_reckoning_core NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    timed_out = 1'b1;
    $display("tb_robot_pose_dead_reckoning_core NOT OK");
    $finish;
  end

endmodule

### sim.f
src/rpdr_pkg.sv
src/robot_pose_dead_reckoning_core.sv
src/rpdr_checker.sv
tb/tb_robot_pose_dead_reckoning_core.sv
